[src/ttsi_pkg.sv]
// Shared types, character codes and the digit decoder for the text-to-integer unit.
package ttsi_pkg;

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_SIGN,
    PH_ZERO,
    PH_XPFX,
    PH_DIGITS,
    PH_DONE
  } parse_phase_t;

  typedef enum logic [1:0] {
    DS_NONE,
    DS_DIGITS,
    DS_OVERFLOW
  } digit_status_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  localparam logic [5:0] BASE_AUTO  = 6'd0;
  localparam logic [5:0] BASE_MIN   = 6'd2;
  localparam logic [5:0] BASE_OCT   = 6'd8;
  localparam logic [5:0] BASE_DEC   = 6'd10;
  localparam logic [5:0] BASE_HEX   = 6'd16;
  localparam logic [5:0] BASE_MAX   = 6'd36;
  localparam logic [5:0] BASE_RESET = 6'd10;

  // above every legal base, so it never passes the digit check
  localparam logic [5:0] NO_DIGIT = 6'd63;

  function automatic logic [5:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = c - (CH_UA - 8'd10);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = c - (CH_LA - 8'd10);
    end else begin
      d = {2'b00, NO_DIGIT};
    end
    return d[5:0];
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
           c == CH_FF || c == CH_VT;
  endfunction

endpackage

[src/text_to_signed_integer_radix_unit.sv]
// Streaming string-to-signed-integer converter, one character per request.
//
// Accepts one character per clock cycle while in_stall is low. A character passes an input
// register and is then folded into the parse state by combinational logic: one
// LONG_BITS x 6 multiply-add and one compare against the signed limit, which
// sets the cycle time. A zero character ends the string; its result is written
// to the output register when the character leaves the input register, and the
// parse state is cleared for the next string. The base register is sampled at
// the first character after whitespace and sign. in_stall rises only when a
// terminating character is waiting and the output register is still held.
module text_to_signed_integer_radix_unit
  import ttsi_pkg::*;
#(
  parameter int LONG_BITS   = 64,
  parameter int OFFSET_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          write_enable,
  input  logic [5:0]                    write_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    character,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [63:0]            value,
  output logic                          overflow,
  output logic                          any_digits,
  output logic [OFFSET_BITS-1:0]        end_offset
);

  localparam int PW = LONG_BITS + 7;
  localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

  logic [5:0]             number_base;
  logic                   s1_valid;
  logic [7:0]             s1_char;

  parse_phase_t           parse_phase, parse_phase_next;
  logic                   negative_sign, negative_sign_next;
  logic [5:0]             active_base, active_base_next;
  logic [LONG_BITS-1:0]   accumulator, accumulator_next;
  digit_status_t          digit_status, digit_status_next;
  logic [OFFSET_BITS-1:0] char_position, char_position_next;

  logic                   advance;
  logic                   fire;
  logic                   term;

  logic                   c_space, c_sign, c_x, zero_pfx;
  logic [5:0]             d, first_base, use_base, take_d;
  logic                   do_first, do_digit, digit_ok, do_take, hex_ok;
  logic                   step_pos, back_pos;
  logic [PW-1:0]          prod, lim;
  logic                   over;

  logic signed [LONG_BITS-1:0] sval;

  // input register moves unless a terminator is blocked by a held result
  assign term     = (s1_char == CH_NUL);
  assign advance  = !s1_valid || !(term && out_valid && out_stall);
  assign in_stall = s1_valid && !advance;
  assign fire     = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= BASE_RESET;
    end else if (write_enable) begin
      number_base <= write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      s1_char <= character;
    end
  end

  // character classification
  assign c_space    = is_space(s1_char);
  assign c_sign     = (s1_char == CH_PLUS) || (s1_char == CH_MINUS);
  assign c_x        = (s1_char == CH_LX) || (s1_char == CH_UX);
  assign d          = digit_of(s1_char);
  assign hex_ok     = (d < BASE_HEX);
  assign zero_pfx   = ((number_base == BASE_AUTO) || (number_base == BASE_HEX)) &&
                      (s1_char == CH_0);
  assign first_base = (number_base == BASE_AUTO) ? BASE_DEC : number_base;

  assign do_first = ((parse_phase == PH_SPACE) && !c_space && !c_sign) ||
                    (parse_phase == PH_SIGN);
  assign use_base = (do_first) ? first_base : active_base;
  assign do_digit = (do_first && !zero_pfx) ||
                    ((parse_phase == PH_ZERO) && !c_x) ||
                    ((parse_phase == PH_XPFX) && hex_ok) ||
                    (parse_phase == PH_DIGITS);
  assign digit_ok = (use_base >= BASE_MIN) && (use_base <= BASE_MAX) && (d < use_base);
  assign do_take  = (do_first && zero_pfx) || (do_digit && digit_ok);
  assign take_d   = (do_first && zero_pfx) ? 6'd0 : d;

  // acc*base + d > lim is the same test as comparing against lim/base and lim%base
  assign prod = PW'(accumulator) * PW'(use_base) + PW'(take_d);
  assign lim  = (PW'(1) << (LONG_BITS - 1)) - PW'(!negative_sign);
  assign over = (digit_status == DS_OVERFLOW) || (prod > lim);

  assign step_pos = ((parse_phase == PH_SPACE) && (c_space || c_sign)) ||
                    ((parse_phase == PH_ZERO) && c_x) ||
                    do_take;
  assign back_pos = (parse_phase == PH_XPFX) && !hex_ok;

  // next phase
  always_comb begin
    parse_phase_next = parse_phase;
    unique case (parse_phase)
      PH_SPACE, PH_SIGN: begin
        if ((parse_phase == PH_SPACE) && c_space) begin
          parse_phase_next = PH_SPACE;
        end else if ((parse_phase == PH_SPACE) && c_sign) begin
          parse_phase_next = PH_SIGN;
        end else if (zero_pfx) begin
          parse_phase_next = PH_ZERO;
        end else begin
          parse_phase_next = digit_ok ? PH_DIGITS : PH_DONE;
        end
      end
      PH_ZERO: begin
        if (c_x) begin
          parse_phase_next = PH_XPFX;
        end else begin
          parse_phase_next = digit_ok ? PH_DIGITS : PH_DONE;
        end
      end
      PH_XPFX: begin
        parse_phase_next = (hex_ok && digit_ok) ? PH_DIGITS : PH_DONE;
      end
      PH_DIGITS: begin
        parse_phase_next = digit_ok ? PH_DIGITS : PH_DONE;
      end
      PH_DONE: begin
        parse_phase_next = PH_DONE;
      end
      default: begin
        parse_phase_next = PH_DONE;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    negative_sign_next = negative_sign;
    active_base_next   = active_base;
    accumulator_next   = accumulator;
    digit_status_next  = digit_status;
    char_position_next = char_position;

    if ((parse_phase == PH_SPACE) && !c_space && c_sign) begin
      negative_sign_next = (s1_char == CH_MINUS);
    end

    if (do_first) begin
      if (zero_pfx) begin
        active_base_next = (number_base == BASE_AUTO) ? BASE_OCT : BASE_HEX;
      end else begin
        active_base_next = first_base;
      end
    end else if ((parse_phase == PH_ZERO) && c_x) begin
      active_base_next = BASE_HEX;
    end

    if (do_take) begin
      if (over) begin
        digit_status_next = DS_OVERFLOW;
      end else begin
        accumulator_next  = prod[LONG_BITS-1:0];
        digit_status_next = DS_DIGITS;
      end
    end

    if (step_pos) begin
      if (char_position != POS_MAX) begin
        char_position_next = char_position + OFFSET_BITS'(1);
      end
    end else if (back_pos) begin
      // "0x" with no hex digit: the offset points back at the x
      if (char_position != POS_MAX && char_position != '0) begin
        char_position_next = char_position - OFFSET_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase   <= PH_SPACE;
      negative_sign <= 1'b0;
      active_base   <= '0;
      accumulator   <= '0;
      digit_status  <= DS_NONE;
      char_position <= '0;
    end else if (fire) begin
      if (term) begin
        parse_phase   <= PH_SPACE;
        negative_sign <= 1'b0;
        active_base   <= '0;
        accumulator   <= '0;
        digit_status  <= DS_NONE;
        char_position <= '0;
      end else begin
        parse_phase   <= parse_phase_next;
        negative_sign <= negative_sign_next;
        active_base   <= active_base_next;
        accumulator   <= accumulator_next;
        digit_status  <= digit_status_next;
        char_position <= char_position_next;
      end
    end
  end

  // result value in LONG_BITS, sign-extended on output
  always_comb begin
    sval = '0;
    unique case (digit_status_next)
      DS_OVERFLOW: begin
        sval = negative_sign_next ? {1'b1, {(LONG_BITS-1){1'b0}}}
                                  : {1'b0, {(LONG_BITS-1){1'b1}}};
      end
      DS_DIGITS: begin
        sval = negative_sign_next ? -accumulator_next : accumulator_next;
      end
      default: begin
        sval = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && term) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && term) begin
      value      <= 64'(sval);
      overflow   <= (digit_status_next == DS_OVERFLOW);
      any_digits <= (digit_status_next != DS_NONE);
      end_offset <= (digit_status_next != DS_NONE) ? char_position_next : '0;
    end
  end

endmodule

[bench/text_to_signed_integer_radix_unit_test.sv]
// Self-checking bench for the streaming text-to-signed-integer unit.
module text_to_signed_integer_radix_unit_test;
  import ttsi_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;
  localparam logic [7:0]  CH_1 = CH_0 + 8'd1;

  typedef struct {
    logic signed [63:0] value;
    logic               overflow;
    logic               any_digits;
    logic [15:0]        end_offset;
  } conv_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               write_enable = 1'b0;
  logic [5:0]         write_data = 6'd0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         character = 8'd0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [63:0] value;
  logic               overflow;
  logic               any_digits;
  logic [15:0]        end_offset;

  // shadow of the parser
  logic [5:0]    base_reg = BASE_RESET;
  parse_phase_t  phase = PH_SPACE;
  logic          neg_sign = 1'b0;
  logic [5:0]    work_base = 6'd0;
  logic [63:0]   acc = 64'd0;
  digit_status_t dstat = DS_NONE;
  logic [15:0]   char_pos = 16'd0;

  conv_result_t pending_results[$];
  conv_result_t head_result;

  bit idle_on = 1'b1;
  int errors = 0;
  int chars_sent = 0;
  int results_seen = 0;
  int overflows_seen = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  text_to_signed_integer_radix_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_data   (write_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .character    (character),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .value        (value),
    .overflow     (overflow),
    .any_digits   (any_digits),
    .end_offset   (end_offset)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned char_digit(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return 32'(c - CH_0);
    if (c >= CH_UA && c <= CH_UZ) return 32'(c - CH_UA) + 10;
    if (c >= CH_LA && c <= CH_LZ) return 32'(c - CH_LA) + 10;
    return 99;
  endfunction

  function automatic bit blank_char(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
           c == CH_FF || c == CH_VT;
  endfunction

  function automatic void step_pos();
    if (char_pos != 16'hFFFF) char_pos = char_pos + 16'd1;
  endfunction

  function automatic void fold_digit(input int unsigned d);
    logic [63:0] lim;
    logic [63:0] cut;
    logic [63:0] cl;
    lim = neg_sign ? NEG_LIMIT : POS_LIMIT;
    cut = lim / work_base;
    cl = lim % work_base;
    // once saturated, later digits are still consumed but not folded
    if (dstat == DS_OVERFLOW || acc > cut || (acc == cut && d > cl)) begin
      dstat = DS_OVERFLOW;
    end else begin
      acc = acc * work_base + d;
      dstat = DS_DIGITS;
    end
  endfunction

  function automatic void digit_step(input logic [7:0] c);
    int unsigned d;
    d = char_digit(c);
    if (work_base >= BASE_MIN && work_base <= BASE_MAX && d < work_base) begin
      fold_digit(d);
      phase = PH_DIGITS;
      step_pos();
    end else begin
      phase = PH_DONE;
    end
  endfunction

  function automatic void lead_step(input logic [7:0] c);
    if ((base_reg == BASE_AUTO || base_reg == BASE_HEX) && c == CH_0) begin
      work_base = (base_reg == BASE_AUTO) ? BASE_OCT : BASE_HEX;
      fold_digit(0);
      phase = PH_ZERO;
      step_pos();
    end else begin
      work_base = (base_reg == BASE_AUTO) ? BASE_DEC : base_reg;
      digit_step(c);
    end
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    conv_result_t res;
    case (phase)
      PH_SPACE: begin
        if (blank_char(c)) begin
          step_pos();
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          neg_sign = (c == CH_MINUS);
          phase = PH_SIGN;
          step_pos();
        end else begin
          lead_step(c);
        end
      end
      PH_SIGN: lead_step(c);
      PH_ZERO: begin
        if (c == CH_LX || c == CH_UX) begin
          work_base = BASE_HEX;
          phase = PH_XPFX;
          step_pos();
        end else begin
          digit_step(c);
        end
      end
      PH_XPFX: begin
        if (char_digit(c) < 16) begin
          digit_step(c);
        end else begin
          // bare prefix: only the zero counts, unless the position is pinned
          if (char_pos != 16'hFFFF && char_pos != 16'd0) char_pos = char_pos - 16'd1;
          phase = PH_DONE;
        end
      end
      PH_DIGITS: digit_step(c);
      default: phase = PH_DONE;
    endcase
    if (c == CH_NUL) begin
      res.overflow = (dstat == DS_OVERFLOW);
      res.any_digits = (dstat != DS_NONE);
      res.end_offset = res.any_digits ? char_pos : 16'd0;
      case (dstat)
        DS_OVERFLOW: res.value = neg_sign ? NEG_LIMIT : POS_LIMIT;
        DS_DIGITS: res.value = neg_sign ? -acc : acc;
        default: res.value = 64'sd0;
      endcase
      pending_results.push_back(res);
      phase = PH_SPACE;
      neg_sign = 1'b0;
      work_base = 6'd0;
      acc = 64'd0;
      dstat = DS_NONE;
      char_pos = 16'd0;
    end
  endfunction

  task automatic send_char(input logic [7:0] c);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    character <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_char(c);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(CH_NUL);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_base(input logic [5:0] b);
    wait_idle();
    write_enable <= 1'b1;
    write_data <= b;
    @(posedge clk);
    write_enable <= 1'b0;
    base_reg = b;
  endtask

  function automatic logic [7:0] digit_char(input int unsigned v);
    if (v < 10) return 8'(CH_0 + v);
    return 8'(($urandom_range(0, 1) ? CH_UA : CH_LA) + v - 10);
  endfunction

  function automatic logic [7:0] random_blank();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_CR;
      4: return CH_FF;
      default: return CH_VT;
    endcase
  endfunction

  function automatic logic [5:0] pick_base();
    case ($urandom_range(0, 7))
      0: return BASE_AUTO;
      1: return BASE_DEC;
      2: return BASE_HEX;
      3: return BASE_MIN;
      4: return BASE_MAX;
      5: return BASE_OCT;
      default: return 6'($urandom_range(0, 63));
    endcase
  endfunction

  // mostly well-formed numbers; some noise, near-limit values and trailing junk
  task automatic send_random_string();
    int kind;
    int minus;
    int eff;
    int n;
    logic [63:0] mag;
    logic [7:0] digs[$];
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(0, 8)) send_char(8'($urandom_range(1, 255)));
    end else begin
      repeat ($urandom_range(0, 3)) send_char(random_blank());
      minus = $urandom_range(0, 2);
      if (minus == 1) send_char(CH_PLUS);
      if (minus == 2) send_char(CH_MINUS);
      eff = (base_reg >= BASE_MIN && base_reg <= BASE_MAX) ? int'(base_reg) : 36;
      if ((base_reg == BASE_AUTO || base_reg == BASE_HEX) && $urandom_range(0, 2) == 0) begin
        send_char(CH_0);
        send_char($urandom_range(0, 1) ? CH_LX : CH_UX);
        eff = 16;
      end else if (base_reg == BASE_AUTO) begin
        eff = $urandom_range(0, 1) ? 8 : 10;
        if (eff == 8) send_char(CH_0);
      end
      if (kind == 1) begin
        mag = (minus == 2) ? NEG_LIMIT : POS_LIMIT;
        mag = mag + 64'($urandom_range(0, 4)) - 64'd2;
        while (mag != 0) begin
          digs.push_front(digit_char(32'(mag % eff)));
          mag = mag / eff;
        end
      end else begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 70) : $urandom_range(0, 12);
        repeat (n) digs.push_back(digit_char($urandom_range(0, eff - 1)));
      end
      foreach (digs[i]) send_char(digs[i]);
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(1, 255)));
      end
    end
    send_char(CH_NUL);
  endtask

  task automatic test_default_decimal();
    send_char(CH_SPACE);
    send_char(CH_TAB);
    send_char(CH_LF);
    send_char(CH_CR);
    send_char(CH_FF);
    send_char(CH_VT);
    send_text("-42");
    send_text("+9223372036854775807");
    send_text("-9223372036854775808");
    send_text("99999999999999999999x");
    send_text("abc");
    send_text("");
    send_text("--5");
    send_char(CH_1);
    send_char(8'hFF);
    send_text("3");
    send_text("0x10");
  endtask

  task automatic test_radix_selection();
    write_base(BASE_AUTO);
    send_text("0x1f");
    send_text("-017");
    send_text("0xg");
    send_text(" 0X");
    send_text("  12");
    send_text("09");
    write_base(BASE_HEX);
    send_text("0XfF");
    send_text("-ff");
    write_base(BASE_MAX);
    send_text("zZ9");
    write_base(BASE_MIN);
    send_text("-1012");
    send_char(CH_MINUS);
    send_char(CH_1);
    repeat (63) send_char(CH_0);
    send_char(CH_NUL);
    repeat (64) send_char(CH_1);
    send_char(CH_NUL);
    write_base(6'd1);
    send_text("1");
    write_base(6'd37);
    send_text("5");
    write_base(6'd63);
    send_text("5");
    write_base(BASE_OCT);
    send_text("778");
  endtask

  task automatic test_offset_tracking();
    write_base(BASE_DEC);
    repeat (30) send_char(CH_SPACE);
    send_text("123456789");
    write_base(BASE_AUTO);
    repeat (30) send_char(CH_SPACE);
    send_text("0xz");
    repeat (31) send_char(CH_SPACE);
    send_text("-0xg");
  endtask

  task automatic test_random_strings();
    int first;
    first = chars_sent;
    while (chars_sent < first + 900) begin
      write_base(pick_base());
      // final stretch runs at full rate on both sides
      if (chars_sent > first + 675) idle_on = 1'b0;
      repeat (12) send_random_string();
    end
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic compare_field(input string what, input logic signed [63:0] want,
                               input logic signed [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none actual value %0d", $time, value);
      end else begin
        head_result = pending_results.pop_front();
        compare_field("value", head_result.value, value);
        compare_field("overflow", head_result.overflow, overflow);
        compare_field("any_digits", head_result.any_digits, any_digits);
        compare_field("end_offset", head_result.end_offset, end_offset);
        results_seen++;
        if (head_result.overflow) overflows_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("text_to_signed_integer_radix_unit_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_default_decimal();
    test_radix_selection();
    test_offset_tracking();
    test_random_strings();
    wait_idle();
    $display("checked %0d strings (%0d saturated) from %0d characters", results_seen,
             overflows_seen, chars_sent);
    $display("bases covered: auto, 2, 8, 10, 16, 36, invalid, plus random; long leading blanks");
    if (errors == 0) begin
      $display("text_to_signed_integer_radix_unit_test: PASS");
    end else begin
      $display("text_to_signed_integer_radix_unit_test: FAIL");
    end
    $finish;
  end

endmodule

[text_to_signed_integer_radix_unit.f]
src/ttsi_pkg.sv
src/text_to_signed_integer_radix_unit.sv
bench/text_to_signed_integer_radix_unit_test.sv
